[rtl/ktm_pkg.sv]
// Shared types and constants for the keyword trie matcher.
package ktm_pkg;

    localparam int unsigned MODE_W = 2;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned LEN_W  = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_CHAR   = 2'd0,
        MODE_INS_END    = 2'd1,
        MODE_MATCH_CHAR = 2'd2,
        MODE_MATCH_END  = 2'd3
    } t_mode;

    // Controller to datapath.
    typedef struct packed {
        logic latch;       // input beat taken
        logic fe_rd;       // read head-of-list pointer of cursor node
        logic take_fe;     // capture head pointer
        logic edge_rd;     // read current edge
        logic take_edge;   // compare edge, follow hit or sibling
        logic miss;        // list exhausted
        logic alloc_edge;  // write new edge, relink cursor node, clear new code
        logic alloc_node;  // terminate new node list, advance cursor and counts
        logic store_code;  // write accept code at cursor
        logic code_rd;     // read accept code at cursor
        logic take_code;   // capture accept code
        logic respond;     // load output register and restart walk
    } t_ktm_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_mode mode;
        logic  failed;
        logic  stopped;
        logic  edge_none;
        logic  hit;
        logic  full;
        logic  out_free;
    } t_ktm_sts;

endpackage

[rtl/keyword_trie_matcher.sv]
// Keyword trie matcher top level: stream ports, controller and datapath.
//
// Input beats carry one command each: the mode on tuser, the character and
// the accept code on tdata. Insert-character and match-character beats give
// no result; insert-end gives an insert status and match-end gives the
// match result (accepted, matched length, code) on the output stream.
// A character beat walks the node's sibling list, one RAM read plus one
// compare per edge, until an edge matches or the list is exhausted; a new
// node in insert mode adds the edge and node writes, and a character
// dropped after a refusal or a mismatch skips the walk. Insert-end and
// match-end load their result into the output register.
// The result register parts the two sides: while a result waits for
// o_m_tready the block keeps accepting beats, and only a second result
// waits in the controller until the register frees up.
// Reset leaves an empty dictionary (root only), no walk in progress and no
// pending result; it needs no clearing pass.
module keyword_trie_matcher import ktm_pkg::*; #(
    parameter int unsigned MAX_NODES = 256,
    parameter int unsigned MAX_EDGES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // character[7:0], option_code[15:8]
    input  logic [1:0]  i_s_tuser,   // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // status[0], accepted[1], match_length[9:2],
                                     // found_code[17:10], zero[23:18]
    output logic [0:0]  o_m_tuser    // answer_kind[0]
);

    t_ktm_cmd          cmd;
    t_ktm_sts          sts;
    logic              out_kind;
    logic              out_status;
    logic              out_accepted;
    logic [LEN_W-1:0]  out_length;
    logic [CODE_W-1:0] out_found;

    ktm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ktm_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_mode     (t_mode'(i_s_tuser)),
        .i_char     (i_s_tdata[7:0]),
        .i_code     (i_s_tdata[15:8]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_kind     (out_kind),
        .o_status   (out_status),
        .o_accepted (out_accepted),
        .o_length   (out_length),
        .o_found    (out_found)
    );

    assign o_m_tdata = {6'd0, out_found, out_length, out_accepted, out_status};
    assign o_m_tuser = out_kind;

`ifndef SYNTHESIS
    a_resp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.respond |-> (!o_m_tvalid || i_m_tready))
        else $error("result loaded over an untaken beat");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.alloc_edge |-> !sts.full)
        else $error("allocation with a full pool");

    a_alloc_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.alloc_edge |=> cmd.alloc_node)
        else $error("edge allocation not followed by node allocation");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.alloc_edge, cmd.alloc_node, cmd.store_code}))
        else $error("conflicting trie writes");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second beat taken while busy");
`endif

endmodule

[rtl/ktm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ktm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ktm_ctrl.sv]
// Sequencer for the trie walk: accept, list search, allocation and response.
module ktm_ctrl import ktm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_ktm_sts i_sts,
    output t_ktm_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FE_WAIT,
        S_CHECK,
        S_EDGE_WAIT,
        S_ALLOC_EDGE,
        S_ALLOC_NODE,
        S_CODE_WAIT,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.mode)
                    MODE_INS_CHAR: begin
                        if (i_sts.failed) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.fe_rd = 1'b1;
                            n_state     = S_FE_WAIT;
                        end
                    end
                    MODE_MATCH_CHAR: begin
                        if (i_sts.stopped) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.fe_rd = 1'b1;
                            n_state     = S_FE_WAIT;
                        end
                    end
                    MODE_INS_END: begin
                        o_cmd.store_code = !i_sts.failed;
                        n_state          = S_RESP;
                    end
                    MODE_MATCH_END: begin
                        o_cmd.code_rd = 1'b1;
                        n_state       = S_CODE_WAIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_FE_WAIT: begin
                o_cmd.take_fe = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.edge_none) begin
                    o_cmd.miss = 1'b1;
                    if (i_sts.mode == MODE_INS_CHAR && !i_sts.full) begin
                        n_state = S_ALLOC_EDGE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_EDGE_WAIT;
                end
            end
            S_EDGE_WAIT: begin
                o_cmd.take_edge = 1'b1;
                n_state         = i_sts.hit ? S_IDLE : S_CHECK;
            end
            S_ALLOC_EDGE: begin
                o_cmd.alloc_edge = 1'b1;
                n_state          = S_ALLOC_NODE;
            end
            S_ALLOC_NODE: begin
                o_cmd.alloc_node = 1'b1;
                n_state          = S_IDLE;
            end
            S_CODE_WAIT: begin
                o_cmd.take_code = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

[rtl/ktm_datapath.sv]
// Trie storage, walk registers and output register.
module ktm_datapath import ktm_pkg::*; #(
    parameter int unsigned MAX_NODES = 256,
    parameter int unsigned MAX_EDGES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ktm_cmd          i_cmd,
    output t_ktm_sts          o_sts,
    input  t_mode             i_mode,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic              o_kind,
    output logic              o_status,
    output logic              o_accepted,
    output logic [LEN_W-1:0]  o_length,
    output logic [CODE_W-1:0] o_found
);

    localparam int unsigned NW  = $clog2(MAX_NODES);
    localparam int unsigned EW  = $clog2(MAX_EDGES);
    localparam int unsigned EPW = EW + 1;              // edge pointer, top bit = none
    localparam int unsigned NCW = $clog2(MAX_NODES + 1);
    localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
    localparam int unsigned ERW = CHAR_W + EPW + NW;   // {char, sibling, target}
    localparam logic [EPW-1:0] EDGE_NONE = {1'b1, {EW{1'b0}}};

    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_INS,
        WALK_MATCH
    } t_walk;

    t_mode             r_mode;
    logic [CHAR_W-1:0] r_ch;
    logic [CODE_W-1:0] r_code;
    t_walk             r_walk,         n_walk;
    logic [NW-1:0]     r_cursor,       n_cursor;
    logic              r_stopped,      n_stopped;
    logic [LEN_W-1:0]  r_consumed,     n_consumed;
    logic              r_failed,       n_failed;
    logic [NCW-1:0]    r_nodes_used,   n_nodes_used;
    logic [ECW-1:0]    r_edges_used,   n_edges_used;
    logic [EPW-1:0]    r_edge,         n_edge;
    logic [EPW-1:0]    r_head,         n_head;
    logic [CODE_W-1:0] r_acc;
    logic              r_root_fe_wr,   n_root_fe_wr;
    logic              r_root_code_wr, n_root_code_wr;
    logic              r_out_valid,    n_out_valid;
    logic              r_out_kind;
    logic              r_out_status;
    logic              r_out_accepted;
    logic [LEN_W-1:0]  r_out_length;
    logic [CODE_W-1:0] r_out_found;

    logic [EPW-1:0]    fe_rdata;
    logic [CODE_W-1:0] code_rdata;
    logic [ERW-1:0]    edge_rdata;
    logic [EPW-1:0]    fe_val;
    logic [CODE_W-1:0] code_val;
    logic [CHAR_W-1:0] e_char;
    logic [EPW-1:0]    e_sib;
    logic [NW-1:0]     e_tgt;
    logic [NW-1:0]     new_node;
    logic [EW-1:0]     new_edge;
    logic              full;
    logic              is_match_end;
    t_walk             in_walk;

    logic              fe_we;
    logic [NW-1:0]     fe_waddr;
    logic [EPW-1:0]    fe_wdata;
    logic              code_we;
    logic [NW-1:0]     code_waddr;
    logic [CODE_W-1:0] code_wdata;

    // Root entry reads as an empty list with code zero until first written.
    assign fe_val   = (r_cursor == '0 && !r_root_fe_wr) ? EDGE_NONE : fe_rdata;
    assign code_val = (r_cursor == '0 && !r_root_code_wr) ? '0 : code_rdata;

    assign e_char   = edge_rdata[ERW-1 -: CHAR_W];
    assign e_sib    = edge_rdata[NW +: EPW];
    assign e_tgt    = edge_rdata[NW-1:0];
    assign new_node = r_nodes_used[NW-1:0];
    assign new_edge = r_edges_used[EW-1:0];
    assign full     = (r_nodes_used >= NCW'(MAX_NODES)) || (r_edges_used >= ECW'(MAX_EDGES));
    assign is_match_end = (r_mode == MODE_MATCH_END);
    assign in_walk  = (i_mode == MODE_MATCH_CHAR || i_mode == MODE_MATCH_END) ?
                      WALK_MATCH : WALK_INS;

    assign fe_we      = i_cmd.alloc_edge || i_cmd.alloc_node;
    assign fe_waddr   = i_cmd.alloc_node ? new_node : r_cursor;
    assign fe_wdata   = i_cmd.alloc_node ? EDGE_NONE : {1'b0, new_edge};
    assign code_we    = i_cmd.alloc_edge || i_cmd.store_code;
    assign code_waddr = i_cmd.alloc_edge ? new_node : r_cursor;
    assign code_wdata = i_cmd.alloc_edge ? '0 : r_code;

    ktm_ram #(.WIDTH(EPW), .DEPTH(MAX_NODES)) u_fe_ram (
        .i_clk   (i_clk),
        .i_we    (fe_we),
        .i_waddr (fe_waddr),
        .i_wdata (fe_wdata),
        .i_re    (i_cmd.fe_rd),
        .i_raddr (r_cursor),
        .o_rdata (fe_rdata)
    );

    ktm_ram #(.WIDTH(CODE_W), .DEPTH(MAX_NODES)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (code_waddr),
        .i_wdata (code_wdata),
        .i_re    (i_cmd.code_rd),
        .i_raddr (r_cursor),
        .o_rdata (code_rdata)
    );

    ktm_ram #(.WIDTH(ERW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc_edge),
        .i_waddr (new_edge),
        .i_wdata ({r_ch, r_head, new_node}),
        .i_re    (i_cmd.edge_rd),
        .i_raddr (r_edge[EW-1:0]),
        .o_rdata (edge_rdata)
    );

    always_comb begin
        n_walk         = r_walk;
        n_cursor       = r_cursor;
        n_stopped      = r_stopped;
        n_consumed     = r_consumed;
        n_failed       = r_failed;
        n_nodes_used   = r_nodes_used;
        n_edges_used   = r_edges_used;
        n_edge         = r_edge;
        n_head         = r_head;
        n_root_fe_wr   = r_root_fe_wr;
        n_root_code_wr = r_root_code_wr;
        n_out_valid    = r_out_valid && !i_m_tready;

        if (i_cmd.latch) begin
            // a beat of the other walk kind restarts at the root
            if (r_walk != WALK_NONE && r_walk != in_walk) begin
                n_cursor   = '0;
                n_stopped  = 1'b0;
                n_consumed = '0;
                n_failed   = 1'b0;
            end
            n_walk = in_walk;
        end
        if (i_cmd.take_fe) begin
            n_edge = fe_val;
            n_head = fe_val;
        end
        if (i_cmd.take_edge) begin
            if (e_char == r_ch) begin
                n_cursor = e_tgt;
                if (r_mode == MODE_MATCH_CHAR && r_consumed != '1) begin
                    n_consumed = r_consumed + LEN_W'(1);
                end
            end else begin
                n_edge = e_sib;
            end
        end
        if (i_cmd.miss) begin
            if (r_mode == MODE_MATCH_CHAR) begin
                n_stopped = 1'b1;
            end else if (full) begin
                n_failed = 1'b1;
            end
        end
        if (i_cmd.alloc_edge && r_cursor == '0) begin
            n_root_fe_wr = 1'b1;
        end
        if (i_cmd.store_code && r_cursor == '0) begin
            n_root_code_wr = 1'b1;
        end
        if (i_cmd.alloc_node) begin
            n_cursor     = new_node;
            n_nodes_used = r_nodes_used + NCW'(1);
            n_edges_used = r_edges_used + ECW'(1);
        end
        if (i_cmd.respond) begin
            n_out_valid = 1'b1;
            n_walk      = WALK_NONE;
            n_cursor    = '0;
            n_stopped   = 1'b0;
            n_consumed  = '0;
            n_failed    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk         <= WALK_NONE;
            r_cursor       <= '0;
            r_stopped      <= 1'b0;
            r_consumed     <= '0;
            r_failed       <= 1'b0;
            r_nodes_used   <= NCW'(1);
            r_edges_used   <= '0;
            r_root_fe_wr   <= 1'b0;
            r_root_code_wr <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_walk         <= n_walk;
            r_cursor       <= n_cursor;
            r_stopped      <= n_stopped;
            r_consumed     <= n_consumed;
            r_failed       <= n_failed;
            r_nodes_used   <= n_nodes_used;
            r_edges_used   <= n_edges_used;
            r_root_fe_wr   <= n_root_fe_wr;
            r_root_code_wr <= n_root_code_wr;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
        r_head <= n_head;
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_ch   <= i_char;
            r_code <= i_code;
        end
        if (i_cmd.take_code) begin
            r_acc <= code_val;
        end
        if (i_cmd.respond) begin
            r_out_kind     <= is_match_end;
            r_out_status   <= !is_match_end && r_failed;
            r_out_accepted <= is_match_end && (r_acc != '0);
            r_out_length   <= (is_match_end && r_acc != '0) ? r_consumed : '0;
            r_out_found    <= is_match_end ? r_acc : '0;
        end
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.failed    = r_failed;
    assign o_sts.stopped   = r_stopped;
    assign o_sts.edge_none = r_edge[EW];
    assign o_sts.hit       = (e_char == r_ch);
    assign o_sts.full      = full;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_status   = r_out_status;
    assign o_accepted = r_out_accepted;
    assign o_length   = r_out_length;
    assign o_found    = r_out_found;

endmodule

[verif/keyword_trie_matcher_tb.sv]
// Self-checking testbench for the keyword trie matcher stream block.
`timescale 1ns / 1ps

module keyword_trie_matcher_tb;
    import ktm_pkg::*;

    localparam int unsigned MAX_NODES   = 256;
    localparam int unsigned MAX_EDGES   = 256;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_WAIT  = 600;
    localparam int unsigned NODE_CAP    = 110;
    localparam int unsigned WORD_SLOTS  = 48;
    localparam logic [8:0]  NO_EDGE     = 9'h1FF;

    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_INSERT,
        WALK_MATCH
    } t_walk;

    typedef struct packed {
        logic              kind;
        logic              status;
        logic              accepted;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    keyword_trie_matcher #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),   // character[7:0], option_code[15:8]
        .i_s_tuser  (s_tuser),   // mode[1:0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata), // status[0], accepted[1], match_length[9:2],
                                 // found_code[17:10], zero[23:18]
        .o_m_tuser  (o_m_tuser)  // answer_kind[0]
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Dictionary mirror
    logic [8:0]        trie_head [MAX_NODES];
    logic [CODE_W-1:0] trie_code [MAX_NODES];
    logic [CHAR_W-1:0] link_char [MAX_EDGES];
    logic [8:0]        link_next [MAX_EDGES];
    logic [7:0]        link_dest [MAX_EDGES];
    int unsigned       node_count;
    int unsigned       link_count;
    logic [7:0]        cur_node;
    logic [LEN_W-1:0]  cur_depth;
    bit                cur_stopped;
    bit                cur_failed;
    t_walk             cur_walk;

    t_answer answers_due [$];

    int unsigned fail_count;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned inserts_done;
    int unsigned inserts_refused;
    int unsigned lookups_done;
    int unsigned lookups_hit;
    int unsigned stall_left;
    bit          gaps_on = 1'b1;

    // Word scratch and stored keywords
    logic [CHAR_W-1:0] word_buf [320];
    int unsigned       word_len;
    logic [CHAR_W-1:0] kw_text [WORD_SLOTS][8];
    int unsigned       kw_len [WORD_SLOTS];
    int unsigned       kw_total;

    function automatic void return_to_root();
        cur_node    = '0;
        cur_depth   = '0;
        cur_stopped = 1'b0;
        cur_failed  = 1'b0;
        cur_walk    = WALK_NONE;
    endfunction

    // Target node of the edge labeled ch leaving node, or -1.
    function automatic int follow_link(logic [7:0] node, logic [CHAR_W-1:0] ch);
        logic [8:0] e;
        e = trie_head[node];
        for (int n = 0; n < MAX_EDGES && e < link_count; n++) begin
            if (link_char[e] == ch) return int'(link_dest[e]);
            e = link_next[e];
        end
        return -1;
    endfunction

    function automatic void predict_beat(t_mode m, logic [CHAR_W-1:0] ch,
                                         logic [CODE_W-1:0] code);
        t_walk   kind;
        int      dest;
        t_answer ans;
        kind = (m == MODE_INS_CHAR || m == MODE_INS_END) ? WALK_INSERT : WALK_MATCH;
        // a beat of the other kind restarts the walk at the root
        if (cur_walk != WALK_NONE && cur_walk != kind) return_to_root();
        cur_walk = kind;
        ans = '0;
        case (m)
            MODE_INS_CHAR: begin
                if (!cur_failed) begin
                    dest = follow_link(cur_node, ch);
                    if (dest >= 0) begin
                        cur_node = dest[7:0];
                    end else if (node_count >= MAX_NODES || link_count >= MAX_EDGES) begin
                        cur_failed = 1'b1;
                    end else begin
                        link_char[link_count] = ch;
                        link_next[link_count] = trie_head[cur_node];
                        link_dest[link_count] = node_count[7:0];
                        trie_head[cur_node]   = link_count[8:0];
                        trie_head[node_count] = NO_EDGE;
                        trie_code[node_count] = '0;
                        cur_node = node_count[7:0];
                        link_count++;
                        node_count++;
                    end
                end
            end
            MODE_INS_END: begin
                ans.status = cur_failed;
                if (cur_failed) inserts_refused++;
                else trie_code[cur_node] = code;
                inserts_done++;
                answers_due.push_back(ans);
                return_to_root();
            end
            MODE_MATCH_CHAR: begin
                if (!cur_stopped) begin
                    dest = follow_link(cur_node, ch);
                    if (dest >= 0) begin
                        cur_node = dest[7:0];
                        if (cur_depth != 8'hFF) cur_depth++;
                    end else begin
                        cur_stopped = 1'b1;
                    end
                end
            end
            default: begin
                ans.kind     = 1'b1;
                ans.accepted = (trie_code[cur_node] != '0);
                ans.length   = ans.accepted ? cur_depth : '0;
                ans.code     = trie_code[cur_node];
                if (ans.accepted) lookups_hit++;
                lookups_done++;
                answers_due.push_back(ans);
                return_to_root();
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(t_mode m, logic [CHAR_W-1:0] ch, logic [CODE_W-1:0] code);
        int unsigned gap;
        gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {code, ch};
        s_tuser  <= m;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        beats_sent++;
        predict_beat(m, ch, code);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        logic [CHAR_W-1:0] alphabet [6];
        alphabet = '{8'h01, 8'h02, 8'h41, 8'h80, 8'hC3, 8'hFF};
        if ($urandom_range(0, 3) == 0) return CHAR_W'($urandom_range(1, 255));
        return alphabet[$urandom_range(0, 5)];
    endfunction

    function automatic void random_word(int unsigned len);
        word_len = len;
        for (int i = 0; i < len; i++) word_buf[i] = pick_char();
    endfunction

    function automatic void load_keyword();
        int unsigned k;
        k = $urandom_range(0, kw_total - 1);
        word_len = kw_len[k];
        for (int i = 0; i < word_len; i++) word_buf[i] = kw_text[k][i];
    endfunction

    function automatic void store_keyword();
        int unsigned k;
        if (kw_total < WORD_SLOTS) begin
            k = kw_total;
            kw_total++;
        end else begin
            k = $urandom_range(0, WORD_SLOTS - 1);
        end
        kw_len[k] = word_len;
        for (int i = 0; i < word_len; i++) kw_text[k][i] = word_buf[i];
    endfunction

    task automatic insert_word(int unsigned len, logic [CODE_W-1:0] code);
        for (int i = 0; i < len; i++)
            send_beat(MODE_INS_CHAR, word_buf[i], CODE_W'($urandom));
        send_beat(MODE_INS_END, CHAR_W'($urandom), code);
    endtask

    task automatic match_word(int unsigned len);
        for (int i = 0; i < len; i++)
            send_beat(MODE_MATCH_CHAR, word_buf[i], CODE_W'($urandom));
        send_beat(MODE_MATCH_END, CHAR_W'($urandom), CODE_W'($urandom));
    endtask

    task automatic random_operation();
        int unsigned       pick;
        bit                allow_new;
        bit                as_insert;
        logic [CODE_W-1:0] code;
        pick = $urandom_range(0, 9);
        // keep the pool for the exhaustion test, unless it is already spent
        allow_new = (node_count <= NODE_CAP) || (node_count >= MAX_NODES);
        if (pick < 3) begin
            if (kw_total > 0 && (!allow_new || $urandom_range(0, 2) == 0)) begin
                load_keyword();
            end else begin
                random_word($urandom_range(1, 6));
                store_keyword();
            end
            code = ($urandom_range(0, 7) == 0) ? '0 : CODE_W'($urandom_range(1, 255));
            insert_word(word_len, code);
        end else if (pick < 8) begin
            if (kw_total > 0 && $urandom_range(0, 3) != 0) begin
                load_keyword();
                case ($urandom_range(0, 2))
                    0: ;
                    1: word_len = $urandom_range(0, word_len);
                    default: begin
                        repeat ($urandom_range(1, 2)) begin
                            word_buf[word_len] = pick_char();
                            word_len++;
                        end
                    end
                endcase
            end else begin
                random_word($urandom_range(0, 6));
            end
            match_word(word_len);
        end else if (pick == 8) begin
            // partial string ended by the other kind of end
            random_word($urandom_range(1, 4));
            as_insert = allow_new && $urandom_range(0, 1);
            for (int i = 0; i < word_len; i++)
                send_beat(as_insert ? MODE_INS_CHAR : MODE_MATCH_CHAR, word_buf[i],
                          CODE_W'($urandom));
            send_beat(as_insert ? MODE_MATCH_END : MODE_INS_END, CHAR_W'($urandom),
                      CODE_W'($urandom));
        end else begin
            send_beat(allow_new ? t_mode'($urandom_range(0, 3))
                                : t_mode'($urandom_range(1, 3)),
                      CHAR_W'($urandom), CODE_W'($urandom));
        end
    endtask

    task automatic test_empty_word();
        send_beat(MODE_MATCH_END, 8'h00, 8'h00);
        send_beat(MODE_INS_END, 8'hFF, 8'hFF);
        send_beat(MODE_MATCH_END, 8'h01, 8'h00);
    endtask

    task automatic test_prefix_match();
        word_buf[0] = 8'hFF; word_buf[1] = 8'h01; word_buf[2] = 8'h55;
        insert_word(2, 8'h01);
        insert_word(1, 8'h80);
        match_word(3);
        word_buf[1] = 8'h55; word_buf[2] = 8'h01;
        // mismatch on the second char, the third is ignored
        match_word(3);
        word_buf[0] = 8'h00; word_buf[1] = 8'h7F;
        insert_word(2, 8'hFE);
        match_word(2);
    endtask

    task automatic test_walk_restart();
        send_beat(MODE_INS_CHAR, 8'hFF, 8'h00);
        send_beat(MODE_MATCH_END, 8'h00, 8'h00);
        send_beat(MODE_MATCH_CHAR, 8'hFF, 8'h00);
        send_beat(MODE_INS_END, 8'hFF, 8'h00);
    endtask

    task automatic test_random_dictionary(int unsigned beat_target);
        while (beats_sent < beat_target) random_operation();
    endtask

    task automatic test_pool_exhaustion();
        int unsigned depth;
        int unsigned cut;
        for (int i = 0; i < 320; i++) word_buf[i] = CHAR_W'($urandom_range(1, 255));
        depth = 0;
        for (int i = 0; i < 320 && !cur_failed; i++) begin
            send_beat(MODE_INS_CHAR, word_buf[i], CODE_W'($urandom));
            if (cur_failed) depth = i;
        end
        // characters after the refusal are dropped
        repeat (3) send_beat(MODE_INS_CHAR, CHAR_W'($urandom), CODE_W'($urandom));
        send_beat(MODE_INS_END, CHAR_W'($urandom), CODE_W'($urandom_range(1, 255)));
        if (depth > 0) begin
            insert_word(depth, CODE_W'($urandom_range(1, 255)));
            match_word(depth + 1);
            cut = (depth > 1) ? $urandom_range(1, depth - 1) : 1;
            insert_word(cut, CODE_W'($urandom_range(1, 255)));
            match_word(cut);
        end
    endtask

    task automatic test_full_dictionary(int unsigned beat_target, int unsigned quiet_target);
        while (beats_sent < beat_target) random_operation();
        gaps_on = 1'b0;
        while (beats_sent < quiet_target) random_operation();
    endtask

    function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
        if (want === got) return 1'b1;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1'b0;
    endfunction

    // Check output beats and drive random stalls
    always @(posedge i_clk) begin
        t_answer want;
        bit      ok;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                fail_count++;
                $display("%0t ns: unexpected result, expected none, actual kind %0d data %h",
                         $time, o_m_tuser[0], o_m_tdata);
            end else begin
                want = answers_due.pop_front();
                ok = field_ok("answer_kind", want.kind, o_m_tuser[0])
                   & field_ok("status", want.status, o_m_tdata[0])
                   & field_ok("accepted", want.accepted, o_m_tdata[1])
                   & field_ok("match_length", want.length, o_m_tdata[9:2])
                   & field_ok("found_code", want.code, o_m_tdata[17:10])
                   & field_ok("padding", 8'h00, {2'b00, o_m_tdata[23:18]});
                if (!ok) fail_count++;
            end
        end
        if (stall_left > 0) stall_left--;
        else if (gaps_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
        m_tready <= (stall_left == 0);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results still due",
                 CYCLE_LIMIT, answers_due.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        trie_head[0] = NO_EDGE;
        trie_code[0] = '0;
        node_count   = 1;
        link_count   = 0;
        return_to_root();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_word();
        test_prefix_match();
        test_walk_restart();
        test_random_dictionary(700);
        test_pool_exhaustion();
        test_full_dictionary(1400, 1650);

        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d beats: %0d inserts (%0d refused on a full pool), %0d lookups (%0d hit)",
                 beats_sent, inserts_done, inserts_refused, lookups_done, lookups_hit);
        $display("Checked %0d results, dictionary ended with %0d nodes", results_seen,
                 node_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
